>>> hdl/lpd_pkg.sv
// Shared types, constants and the log table generator for the log peak decimator.
package lpd_pkg;

  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // 100 * ln(2) in Q16
  localparam logic [22:0] LN2_X100_Q16 = 23'd4542609;
  localparam logic [15:0] VALUE_MAX    = 16'hFFFF;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic CFG_DECIM_STEP   = 1'b0;
  localparam logic CFG_LAST_SEGMENT = 1'b1;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_MAX,
    CLS_LOG
  } cls_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  segment_number;
    logic [31:0] sample_bits;
    logic        last_in_message;
  } in_t;

  typedef struct packed {
    logic        bin_valid;
    logic [15:0] bin_value;
    logic [11:0] bin_index;
    logic        sweep_done;
    logic [12:0] bins_in_frame;
  } out_t;

  // Classified item passed from the front to the back
  typedef struct packed {
    logic        kind;
    logic [2:0]  seg;
    logic        last;
    logic [15:0] value;
  } tok_t;

  // log2(1 + k / 2^bits) in Q16 by repeated squaring; evaluated at elaboration
  function automatic logic [15:0] lut_entry(input int unsigned k, input int unsigned bits);
    logic [63:0] y;
    logic [15:0] r;
    y = (64'd1 << 30) + (64'(k) << (30 - bits));
    r = '0;
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      r = {r[14:0], 1'b0};
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        r[0] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

>>> hdl/lpd_front.sv
// Front end: decodes float32 samples and computes 100*ln(x) in a three-stage pipeline.
module lpd_front #(
  parameter int unsigned LUT_BITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  lpd_pkg::in_t  in_data,
  output logic          tok_valid,
  output lpd_pkg::tok_t tok_data,
  output logic [1:0]    inflight
);

  localparam int unsigned LUT_DEPTH = 2 ** LUT_BITS;

  logic [15:0] lut_rom [LUT_DEPTH];

  for (genvar g = 0; g < LUT_DEPTH; g++) begin : g_lut
    assign lut_rom[g] = lpd_pkg::lut_entry(32'(g), LUT_BITS);
  end

  // stage A: decode
  logic                a_vld_r;
  logic                a_kind_r, a_last_r;
  logic [2:0]          a_seg_r;
  logic [6:0]          a_exp_r;
  logic [LUT_BITS-1:0] a_idx_r;
  lpd_pkg::cls_t       a_cls_r;
  // stage B: table read
  logic                b_vld_r;
  logic                b_kind_r, b_last_r;
  logic [2:0]          b_seg_r;
  logic [6:0]          b_exp_r;
  logic [15:0]         b_t_r;
  lpd_pkg::cls_t       b_cls_r;
  // stage C: product
  logic                c_vld_r;
  logic                c_kind_r, c_last_r;
  logic [2:0]          c_seg_r;
  logic [45:0]         c_prod_r;
  lpd_pkg::cls_t       c_cls_r;

  logic                sgn;
  logic [7:0]          ef;
  logic [22:0]         mant;
  lpd_pkg::cls_t       cls_nxt;
  logic [22:0]         l_sum;

  always_comb begin
    sgn  = in_data.sample_bits[31];
    ef   = in_data.sample_bits[30:23];
    mant = in_data.sample_bits[22:0];
    if (ef == 8'hFF) begin
      cls_nxt = (!sgn && mant == '0) ? lpd_pkg::CLS_MAX : lpd_pkg::CLS_ZERO;
    end else if (sgn || ef < 8'd127) begin
      cls_nxt = lpd_pkg::CLS_ZERO;
    end else begin
      cls_nxt = lpd_pkg::CLS_LOG;
    end
    l_sum = {b_exp_r, 16'h0000} + 23'(b_t_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= accept;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_kind_r <= in_data.kind;
    a_last_r <= in_data.last_in_message;
    a_seg_r  <= in_data.segment_number;
    a_exp_r  <= 7'(ef - 8'd127);
    a_idx_r  <= mant[22 -: LUT_BITS];
    a_cls_r  <= cls_nxt;

    b_kind_r <= a_kind_r;
    b_last_r <= a_last_r;
    b_seg_r  <= a_seg_r;
    b_exp_r  <= a_exp_r;
    b_t_r    <= lut_rom[a_idx_r];
    b_cls_r  <= a_cls_r;

    c_kind_r <= b_kind_r;
    c_last_r <= b_last_r;
    c_seg_r  <= b_seg_r;
    c_prod_r <= 46'(l_sum) * 46'(lpd_pkg::LN2_X100_Q16);
    c_cls_r  <= b_cls_r;
  end

  always_comb begin
    tok_valid     = c_vld_r;
    tok_data.kind = c_kind_r;
    tok_data.seg  = c_seg_r;
    tok_data.last = c_last_r;
    case (c_cls_r)
      lpd_pkg::CLS_MAX: tok_data.value = lpd_pkg::VALUE_MAX;
      lpd_pkg::CLS_LOG: tok_data.value = 16'(c_prod_r[45:32]);
      default:          tok_data.value = '0;
    endcase
    inflight = 2'(a_vld_r) + 2'(b_vld_r) + 2'(c_vld_r);
  end

endmodule

>>> hdl/lpd_fifo.sv
// Short queue of classified items between the front and the back.
module lpd_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  lpd_pkg::tok_t            push_data,
  input  logic                     pop,
  output lpd_pkg::tok_t            pop_data,
  output logic                     not_empty,
  output logic [lpd_pkg::QCW-1:0]  count
);

  lpd_pkg::tok_t               mem_r [lpd_pkg::QDEPTH];
  logic [lpd_pkg::QAW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [lpd_pkg::QCW-1:0]     count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign pop_data  = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

>>> hdl/lpd_back.sv
// Back end: peak hold, grouping, bin counting, sweep end and the output register.
module lpd_back #(
  parameter int unsigned MAX_BINS = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          tok_avail,
  input  lpd_pkg::tok_t tok_data,
  output logic          tok_pop,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lpd_pkg::out_t out_data
);

  localparam int unsigned BCW = $clog2(MAX_BINS + 1);

  logic [7:0]     decim_step_r;
  logic [2:0]     last_segment_r;
  logic [15:0]    peak_r, peak_nxt;
  logic [7:0]     phase_r, phase_nxt;
  logic [BCW-1:0] bin_cnt_r, bin_cnt_nxt;
  logic [2:0]     seg_r, seg_nxt;
  logic           out_valid_r;
  lpd_pkg::out_t  out_data_r;

  logic           bin_vld, done;
  logic [15:0]    pk, bin_val;
  logic [BCW-1:0] bin_idx;
  logic [7:0]     step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decim_step_r   <= 8'd8;
      last_segment_r <= 3'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        lpd_pkg::CFG_DECIM_STEP:   decim_step_r   <= cfg_data;
        lpd_pkg::CFG_LAST_SEGMENT: last_segment_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // take a new item whenever the output register is free or being drained
  assign tok_pop = tok_avail && (!out_valid_r || !out_stall);

  always_comb begin
    peak_nxt    = peak_r;
    phase_nxt   = phase_r;
    bin_cnt_nxt = bin_cnt_r;
    seg_nxt     = seg_r;
    bin_vld     = 1'b0;
    bin_val     = '0;
    bin_idx     = '0;
    step        = (decim_step_r == '0) ? 8'd1 : decim_step_r;
    pk          = (tok_data.value > peak_r) ? tok_data.value : peak_r;
    if (tok_data.kind == lpd_pkg::KIND_HEADER) begin
      seg_nxt   = tok_data.seg;
      if (tok_data.seg == '0) begin
        bin_cnt_nxt = '0;
      end
      peak_nxt  = '0;
      phase_nxt = '0;
    end else begin
      if ({1'b0, phase_r} + 9'd1 >= {1'b0, step}) begin
        if (bin_cnt_r < BCW'(MAX_BINS)) begin
          bin_vld     = 1'b1;
          bin_val     = pk;
          bin_idx     = bin_cnt_r;
          bin_cnt_nxt = bin_cnt_r + 1'b1;
        end
        peak_nxt  = '0;
        phase_nxt = '0;
      end else begin
        peak_nxt  = pk;
        phase_nxt = phase_r + 8'd1;
      end
    end
    done = tok_data.last && (seg_nxt == last_segment_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r      <= '0;
      phase_r     <= '0;
      bin_cnt_r   <= '0;
      seg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (tok_pop) begin
        peak_r      <= peak_nxt;
        phase_r     <= phase_nxt;
        bin_cnt_r   <= bin_cnt_nxt;
        seg_r       <= seg_nxt;
        out_valid_r <= bin_vld || done;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop) begin
      out_data_r.bin_valid     <= bin_vld;
      out_data_r.bin_value     <= bin_val;
      out_data_r.bin_index     <= 12'(bin_idx);
      out_data_r.sweep_done    <= done;
      out_data_r.bins_in_frame <= done ? 13'(bin_cnt_nxt) : 13'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/log_peak_decimator.sv
// Top level of the log peak decimator: front pipeline, queue and back end.
//
// Input channel (in_valid/in_stall/in_data): a message is a header item
// (kind 0, segment number) followed by float32 power samples (kind 1).
// Each sample becomes 100*ln(x) clamped to 0..65535; the peak over every
// decim_step samples is sent as one display bin on the result channel
// (out_valid/out_stall/out_data), which also flags the end of a sweep.
// Configuration writes (cfg_valid/cfg_ready) are always taken.
// Throughput: one item per cycle while in_stall is low. An item that causes a
// result shows it on out_valid after the 3 log stages, the queue write and
// the output register. Items without a result leave nothing.
// The log unit feeds an 8-entry queue; in_stall rises when the queue and
// the three log stages together hold 8 items, so a stalled receiver backs
// up into the input once 8 items wait behind the held result. A held result
// stays on out_data.
// Reset clears the peak, phase, bin counter and segment, empties the queue
// and the pipeline, and restores decim_step to 8 and last_segment to 7.
module log_peak_decimator #(
  parameter int unsigned MAX_BINS     = 4096,
  parameter int unsigned LOG_LUT_BITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lpd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lpd_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data
);

  logic                       in_accept;
  logic                       tok_valid, tok_pop, q_avail;
  lpd_pkg::tok_t              tok_data, q_data;
  logic [1:0]                 inflight;
  logic [lpd_pkg::QCW-1:0]    q_count;
  logic [lpd_pkg::QCW:0]      occupancy;

  assign occupancy = (lpd_pkg::QCW + 1)'(q_count) + (lpd_pkg::QCW + 1)'(inflight);
  assign in_stall  = (occupancy >= (lpd_pkg::QCW + 1)'(lpd_pkg::QDEPTH));
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  lpd_front #(
    .LUT_BITS (LOG_LUT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .in_data   (in_data),
    .tok_valid (tok_valid),
    .tok_data  (tok_data),
    .inflight  (inflight)
  );

  lpd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tok_valid),
    .push_data (tok_data),
    .pop       (tok_pop),
    .pop_data  (q_data),
    .not_empty (q_avail),
    .count     (q_count)
  );

  lpd_back #(
    .MAX_BINS (MAX_BINS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_avail (q_avail),
    .tok_data  (q_data),
    .tok_pop   (tok_pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> hdl/lpd_checker.sv
// Port-level assertions for the log peak decimator and their bind.
module lpd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_stall,
  input lpd_pkg::out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.bin_valid || out_data.sweep_done)
    else $error("result carries neither a bin nor a sweep end");

  a_bin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.bin_valid |-> out_data.bin_value == '0 && out_data.bin_index == '0)
    else $error("bin fields set without a bin");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.sweep_done |-> out_data.bins_in_frame == '0)
    else $error("bin count set without sweep end");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind log_peak_decimator lpd_checker u_lpd_checker (.*);

>>> verif/tb_log_peak_decimator.sv
// Self-checking testbench for the log peak decimator, with a peak-hold bin scoreboard.
module tb_log_peak_decimator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_BINS   = 4096;
  localparam int unsigned LONG_FRAME   = 400;
  localparam int unsigned SETTLE_TICKS = 24;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  // Predicts display bins from accepted transactions and checks the result stream.
  class peak_bin_scoreboard;
    logic [7:0]    step_reg;
    logic [2:0]    last_seg_reg;
    logic [15:0]   peak;
    logic [7:0]    phase;
    logic [12:0]   stored;
    logic [2:0]    seg;
    logic [15:0]   mant_log2 [256];
    lpd_pkg::out_t expected_bins [$];
    int unsigned   errors;

    function new();
      logic [63:0] y;
      logic [15:0] r;
      step_reg     = 8'd8;
      last_seg_reg = 3'd7;
      peak         = '0;
      phase        = '0;
      stored       = '0;
      seg          = '0;
      errors       = 0;
      // log2(1 + k/256) in Q16: square in Q30, pull one bit out whenever y reaches 2
      for (int k = 0; k < 256; k++) begin
        y = (64'd1 << 30) | (64'(k) << 22);
        r = '0;
        for (int i = 0; i < 16; i++) begin
          y = (y * y) >> 30;
          r = r << 1;
          if (y[31]) begin
            y    = y >> 1;
            r[0] = 1'b1;
          end
        end
        mant_log2[k] = r;
      end
    endfunction

    function void write_reg(logic idx, logic [7:0] val);
      if (idx == lpd_pkg::CFG_DECIM_STEP) step_reg = val;
      else last_seg_reg = val[2:0];
    endfunction

    // 100*ln(x) of a float32 pattern, truncated and clamped
    function logic [15:0] centi_ln(logic [31:0] bits);
      logic [63:0] acc;
      if (bits[30:23] == 8'hFF)
        return (!bits[31] && bits[22:0] == '0) ? lpd_pkg::VALUE_MAX : 16'd0;
      if (bits[31] || bits[30:23] < 8'd127)
        return 16'd0;
      acc = (64'(bits[30:23] - 8'd127) << 16) + 64'(mant_log2[bits[22:15]]);
      acc = (acc * 64'(lpd_pkg::LN2_X100_Q16)) >> 32;
      return (acc > 64'(lpd_pkg::VALUE_MAX)) ? lpd_pkg::VALUE_MAX : acc[15:0];
    endfunction

    function void note_item(lpd_pkg::in_t item);
      lpd_pkg::out_t want;
      logic [15:0]   v;
      int unsigned   span;
      want = '0;
      if (item.kind == lpd_pkg::KIND_HEADER) begin
        seg = item.segment_number;
        if (seg == 3'd0) stored = '0;
        peak  = '0;
        phase = '0;
      end else begin
        v    = centi_ln(item.sample_bits);
        span = (step_reg == 8'd0) ? 1 : step_reg;
        if (v > peak) peak = v;
        if (int'(phase) + 1 >= span) begin
          // a full frame drops the bin but still closes the group
          if (stored < FRAME_BINS) begin
            want.bin_valid = 1'b1;
            want.bin_value = peak;
            want.bin_index = stored[11:0];
            stored         = stored + 13'd1;
          end
          peak  = '0;
          phase = '0;
        end else begin
          phase = phase + 8'd1;
        end
      end
      if (item.last_in_message && seg == last_seg_reg) begin
        want.sweep_done    = 1'b1;
        want.bins_in_frame = stored;
      end
      if (want.bin_valid || want.sweep_done) expected_bins.push_back(want);
    endfunction

    function void match(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_bin(lpd_pkg::out_t got);
      lpd_pkg::out_t want;
      if (expected_bins.size() == 0) begin
        $error("result with no transaction pending: %h", got);
        errors++;
        return;
      end
      want = expected_bins.pop_front();
      match("bin_valid", 16'(want.bin_valid), 16'(got.bin_valid));
      match("bin_value", want.bin_value, got.bin_value);
      match("bin_index", 16'(want.bin_index), 16'(got.bin_index));
      match("sweep_done", 16'(want.sweep_done), 16'(got.sweep_done));
      match("bins_in_frame", 16'(want.bins_in_frame), 16'(got.bins_in_frame));
    endfunction
  endclass

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  lpd_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  lpd_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic          cfg_index = lpd_pkg::CFG_DECIM_STEP;
  logic [7:0]    cfg_data  = '0;

  peak_bin_scoreboard sb;
  bit          quiet      = 1'b0;
  int unsigned gap_pct    = 0;
  int unsigned cycle_count = 0;

  log_peak_decimator #(
    .MAX_BINS    (FRAME_BINS),
    .LOG_LUT_BITS(8)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) sb.check_bin(out_data);
  end

  // Receiver backpressure: free runs of varied length, then a stall burst
  initial begin
    forever begin
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 120 : 25)) @(posedge clk);
      if (!quiet) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic lpd_pkg::in_t make_item(logic kind, logic [2:0] seg, logic [31:0] bits,
                                             logic last);
    lpd_pkg::in_t it;
    it.kind            = kind;
    it.segment_number  = seg;
    it.sample_bits     = bits;
    it.last_in_message = last;
    return it;
  endfunction

  function automatic logic [31:0] pick_sample();
    logic [31:0] specials [9];
    specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'h7F80_0001, 32'h0040_0000, 32'h3F7F_FFFF,
                 32'h3F80_0000};
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return specials[$urandom_range(0, 8)];
      2:       return {1'b0, 8'($urandom_range(0, 126)), 23'($urandom)};
      3:       return {1'b0, 8'($urandom_range(200, 254)), 23'($urandom)};
      default: return {1'b0, 8'($urandom_range(127, 150)), 23'($urandom)};
    endcase
  endfunction

  task automatic send_item(lpd_pkg::in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_item(item);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Hold the input until every expected bin is out and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_bins.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(logic [7:0] step, logic [2:0] last_seg);
    settle();
    cfg_write(lpd_pkg::CFG_DECIM_STEP, step);
    // upper bits of the segment write are don't-care; toggle them anyway
    cfg_write(lpd_pkg::CFG_LAST_SEGMENT, {5'($urandom), last_seg});
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed messages with random content; the rest stray transactions
  task automatic run_traffic(int unsigned budget);
    int unsigned sent;
    int unsigned n;
    int unsigned span;
    logic [2:0]  seg;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 88) begin
        span = (sb.step_reg == 8'd0) ? 1 : sb.step_reg;
        n    = $urandom_range(0, 2 * span + 3);
        seg  = ($urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
        send_item(make_item(lpd_pkg::KIND_HEADER, seg, $urandom, n == 0));
        sent++;
        for (int i = 1; i <= n; i++) begin
          send_item(make_item(lpd_pkg::KIND_SAMPLE, 3'($urandom), pick_sample(),
                              i == n || $urandom_range(0, 49) == 0));
          sent++;
        end
      end else begin
        send_item(make_item(1'($urandom), 3'($urandom), pick_sample(), 1'($urandom)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [31:0] corner [12];
    corner = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h007F_FFFF,
               32'h3F7F_FFFF, 32'h3F80_0000, 32'h7F80_0000, 32'hFF80_0000,
               32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'h402D_F854};
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Step of zero, sweep ends on segment 0: every sample is its own bin
    gap_pct = 25;
    configure(8'd0, 3'd0);
    send_item(make_item(lpd_pkg::KIND_HEADER, 3'd0, 32'hFFFF_FFFF, 1'b0));
    foreach (corner[i])
      send_item(make_item(lpd_pkg::KIND_SAMPLE, 3'd7, corner[i], i == 11));
    send_item(make_item(lpd_pkg::KIND_HEADER, 3'd0, 32'h0, 1'b1));
    // samples with no header continue the current segment
    send_item(make_item(lpd_pkg::KIND_SAMPLE, 3'd5, 32'h4120_0000, 1'b0));
    send_item(make_item(lpd_pkg::KIND_SAMPLE, 3'd2, 32'h4480_0000, 1'b1));

    // Lower the step while a group is open: the next sample closes it
    configure(8'd8, 3'd7);
    send_item(make_item(lpd_pkg::KIND_HEADER, 3'd3, 32'h0, 1'b0));
    for (int i = 0; i < 5; i++)
      send_item(make_item(lpd_pkg::KIND_SAMPLE, 3'd0,
                          32'h4100_0000 + 32'(i) * 32'h0080_0000, 1'b0));
    configure(8'd2, 3'd7);
    send_item(make_item(lpd_pkg::KIND_SAMPLE, 3'd0, 32'h3FC0_0000, 1'b1));

    configure(8'd1, 3'd0);
    gap_pct = 30;
    run_traffic(250);

    configure(8'd255, 3'd7);
    gap_pct = 20;
    run_traffic(200);

    configure(8'($urandom_range(2, 12)), 3'($urandom));
    gap_pct = 10;
    run_traffic(250);

    // Long frame at one bin per sample; the closing header reports the count
    configure(8'd1, 3'd5);
    gap_pct = 5;
    send_item(make_item(lpd_pkg::KIND_HEADER, 3'd0, 32'h0, 1'b0));
    for (int i = 0; i < LONG_FRAME; i++)
      send_item(make_item(lpd_pkg::KIND_SAMPLE, 3'($urandom), pick_sample(), 1'b0));
    send_item(make_item(lpd_pkg::KIND_HEADER, 3'd5, 32'h0, 1'b1));

    configure(8'd3, 3'd3);
    gap_pct = 40;
    run_traffic(250);

    configure(8'($urandom_range(1, 6)), 3'($urandom));
    quiet = 1'b1;
    run_traffic(250);

    settle();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
